FILE: design/m3au_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix 3x3 arithmetic unit package
// Shared types, command codes and the saturation helper.
// ----------------------------------------------------------------------------
package m3au_pkg;

	localparam int ELEMS              = 9;
	localparam int DIM                = 3;
	localparam int FRACTION_BITS_DEF  = 16;

	typedef enum logic [3:0] {
		CMD_LOAD_A = 4'd0,
		CMD_LOAD_B = 4'd1,
		CMD_LOAD_V = 4'd2,
		CMD_ADD    = 4'd3,
		CMD_SUB    = 4'd4,
		CMD_SCALE  = 4'd5,
		CMD_MUL    = 4'd6,
		CMD_DET    = 4'd7,
		CMD_MATVEC = 4'd8,
		CMD_EQUAL  = 4'd9
	} cmd_e;

	// Micro-operation carried down the datapath pipeline.
	typedef enum logic [3:0] {
		UOP_ADD   = 4'd0,
		UOP_SUB   = 4'd1,
		UOP_SCALE = 4'd2,
		UOP_MUL   = 4'd3,
		UOP_MV    = 4'd4,
		UOP_DX    = 4'd5,
		UOP_DF    = 4'd6,
		UOP_DS    = 4'd7,
		UOP_EQ    = 4'd8
	} uop_e;

	typedef struct packed {
		logic       [3:0]  command;
		logic       [3:0]  index;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic       [3:0]  position;
		logic              last;
		logic              equal;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		uop_e       uop;
		logic       first;
		logic       emit;
		logic       last;
		logic       neg;
		logic [3:0] pos;
	} uop_ctrl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sh0_7FFF_FFFF;
		lo = -66'sh0_8000_0000;
		if (x > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (x < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/matrix3x3_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix 3x3 arithmetic unit
// Holds matrices A, B and a 3-vector in signed fixed point and computes
// sums, scaling, products, determinant, matrix-vector product and equality.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on the req channel (req_valid/req_stall).
// Loads write one element and return nothing. Each other command runs a
// sequencer over the element stores: add, subtract, scale and equality
// step over the nine elements, the matrix product and the matrix-vector
// product run an inner loop for each result, and the determinant runs six
// terms of four steps, one of them a bubble that waits for the saturated
// first product. The single shared 32x32 multiplier and the one read port
// on each store set this stepping. Each result beat passes the store read
// register, the product and sum register and the output register after
// the sequencer step that completes it. The block takes the next command
// once the pipeline has drained, even while the last result still waits
// on the rsp channel. Results leave through one output register. While
// rsp_stall holds a full output register, the sequencer, the store reads
// and the pipeline freeze in place and resume without loss.
// Reset clears all stores to zero through per-entry valid bits, so the
// block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module matrix3x3_arithmetic_unit #(
	parameter int FRACTION_BITS = m3au_pkg::FRACTION_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire m3au_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output m3au_pkg::rsp_t        rsp
);
	import m3au_pkg::*;

	logic               accept;
	logic               is_compute;
	logic               adv;
	logic               seq_busy;
	logic               pipe_busy;
	logic [3:0]         addr_a;
	logic [3:0]         addr_b;
	logic [1:0]         addr_v;
	uop_ctrl_t          ctrl;
	logic signed [31:0] rd_a;
	logic signed [31:0] rd_b;
	logic signed [31:0] rd_v;
	logic signed [31:0] scalar_q;
	logic               wr_a;
	logic               wr_b;
	logic               wr_v;

	// The whole pipeline holds while a finished beat waits on a stalled receiver.
	assign adv        = !(rsp_valid && rsp_stall);
	assign req_stall  = seq_busy | pipe_busy;
	assign accept     = req_valid && !req_stall;
	assign is_compute = (req.command >= CMD_ADD) && (req.command <= CMD_EQUAL);

	// Out-of-range load indexes leave the stores untouched.
	assign wr_a = accept && (req.command == CMD_LOAD_A) && (req.index < 4'(ELEMS));
	assign wr_b = accept && (req.command == CMD_LOAD_B) && (req.index < 4'(ELEMS));
	assign wr_v = accept && (req.command == CMD_LOAD_V) && (req.index < 4'(DIM));

	always_ff @(posedge clk) begin
		if (accept && req.command == CMD_SCALE) begin
			scalar_q <= req.value;
		end
	end

	m3au_mem #(.DEPTH(ELEMS)) u_mem_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_a),
		.wr_addr (req.index),
		.wr_data (req.value),
		.rd_en   (adv),
		.rd_addr (addr_a),
		.rd_data (rd_a)
	);

	m3au_mem #(.DEPTH(ELEMS)) u_mem_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_b),
		.wr_addr (req.index),
		.wr_data (req.value),
		.rd_en   (adv),
		.rd_addr (addr_b),
		.rd_data (rd_b)
	);

	m3au_mem #(.DEPTH(DIM)) u_mem_v (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_v),
		.wr_addr (req.index[1:0]),
		.wr_data (req.value),
		.rd_en   (adv),
		.rd_addr (addr_v),
		.rd_data (rd_v)
	);

	m3au_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && is_compute),
		.command (req.command),
		.adv     (adv),
		.busy    (seq_busy),
		.addr_a  (addr_a),
		.addr_b  (addr_b),
		.addr_v  (addr_v),
		.ctrl    (ctrl)
	);

	m3au_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctrl      (ctrl),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.rd_v      (rd_v),
		.scalar    (scalar_q),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.pipe_busy (pipe_busy)
	);

	// A new result beat can only come out of a command still in the pipeline.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(pipe_busy))
		else $error("result beat without a command in flight");

	// A load accepted while no result is pending produces no beat.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_compute && !rsp_valid) |=> !rsp_valid)
		else $error("load produced a result beat");

	// A compute command holds off the next command in the cycle after it is accepted.
	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_compute) |=> req_stall)
		else $error("command accepted while a computation started");

endmodule
`default_nettype wire

FILE: design/m3au_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Element store
// Synchronous memory with one write and one registered read port. Entries
// never written since reset read as zero.
// ----------------------------------------------------------------------------
module m3au_mem #(
	parameter int DEPTH = 9,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic signed [31:0]    wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic signed [31:0]         rd_data
);
	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= valid_q[rd_addr] ? mem[rd_addr] : 32'sd0;
		end
	end

endmodule
`default_nettype wire

FILE: design/m3au_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command sequencer
// Steps through element and inner indexes, drives memory read addresses and
// issues one micro-operation per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module m3au_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [3:0]           command,
	input  wire logic                 adv,
	output logic                      busy,
	output logic [3:0]                addr_a,
	output logic [3:0]                addr_b,
	output logic [1:0]                addr_v,
	output m3au_pkg::uop_ctrl_t       ctrl
);
	import m3au_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t     state_q;
	logic [3:0] op_q;
	logic [3:0] k_q;
	logic [1:0] c_q;
	logic [3:0] kmax;
	logic [1:0] cmax;
	logic [3:0] row;
	logic [3:0] col;

	function automatic logic [3:0] times3(input logic [3:0] r);
		times3 = {r[2:0], 1'b0} + r;
	endfunction

	// Sarrus terms: first, second and third factor of each triple.
	function automatic logic [3:0] det_addr(input logic [3:0] t, input logic [1:0] f);
		logic [11:0] e;
		unique case (t)
			4'd0:    e = {4'd0, 4'd4, 4'd8};
			4'd1:    e = {4'd1, 4'd5, 4'd6};
			4'd2:    e = {4'd2, 4'd3, 4'd7};
			4'd3:    e = {4'd2, 4'd4, 4'd6};
			4'd4:    e = {4'd1, 4'd3, 4'd8};
			4'd5:    e = {4'd0, 4'd5, 4'd7};
			default: e = '0;
		endcase
		unique case (f)
			2'd0:    det_addr = e[11:8];
			2'd1:    det_addr = e[7:4];
			default: det_addr = e[3:0];
		endcase
	endfunction

	assign busy = (state_q == S_RUN);
	assign row  = (k_q >= 4'd6) ? 4'd2 : (k_q >= 4'd3) ? 4'd1 : 4'd0;
	assign col  = k_q - times3(row);

	always_comb begin
		kmax   = 4'd8;
		cmax   = 2'd0;
		ctrl   = '0;
		addr_a = k_q;
		addr_b = k_q;
		addr_v = c_q;
		ctrl.valid = (state_q == S_RUN);
		ctrl.pos   = k_q;
		ctrl.last  = (k_q == kmax);
		unique case (op_q)
			CMD_ADD: begin
				ctrl.uop   = UOP_ADD;
				ctrl.first = 1'b1;
				ctrl.emit  = 1'b1;
			end
			CMD_SUB: begin
				ctrl.uop   = UOP_SUB;
				ctrl.first = 1'b1;
				ctrl.emit  = 1'b1;
			end
			CMD_SCALE: begin
				ctrl.uop   = UOP_SCALE;
				ctrl.first = 1'b1;
				ctrl.emit  = 1'b1;
			end
			CMD_EQUAL: begin
				ctrl.uop   = UOP_EQ;
				ctrl.first = (k_q == 4'd0);
				ctrl.emit  = (k_q == 4'd8);
				ctrl.pos   = 4'd0;
			end
			CMD_MUL: begin
				cmax       = 2'd2;
				ctrl.uop   = UOP_MUL;
				ctrl.first = (c_q == 2'd0);
				ctrl.emit  = (c_q == 2'd2);
				addr_a     = times3(row) + {2'd0, c_q};
				addr_b     = times3({2'd0, c_q}) + col;
			end
			CMD_MATVEC: begin
				kmax       = 4'd2;
				cmax       = 2'd2;
				ctrl.uop   = UOP_MV;
				ctrl.first = (c_q == 2'd0);
				ctrl.emit  = (c_q == 2'd2);
				ctrl.last  = (k_q == 4'd2);
				addr_a     = times3(k_q) + {2'd0, c_q};
			end
			CMD_DET: begin
				// Phases: load x, multiply x*y, bubble, multiply by z.
				kmax       = 4'd5;
				cmax       = 2'd3;
				ctrl.pos   = 4'd0;
				ctrl.last  = 1'b1;
				ctrl.first = (k_q == 4'd0);
				ctrl.emit  = (k_q == 4'd5) && (c_q == 2'd3);
				ctrl.neg   = (k_q >= 4'd3);
				unique case (c_q)
					2'd0: begin
						ctrl.uop = UOP_DX;
						addr_a   = det_addr(k_q, 2'd0);
					end
					2'd1: begin
						ctrl.uop = UOP_DF;
						addr_a   = det_addr(k_q, 2'd1);
					end
					2'd2: begin
						ctrl.uop   = UOP_DX;
						ctrl.valid = 1'b0;
					end
					default: begin
						ctrl.uop = UOP_DS;
						addr_a   = det_addr(k_q, 2'd2);
					end
				endcase
			end
			default: begin
				ctrl.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
			k_q     <= '0;
			c_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						op_q    <= command;
						k_q     <= '0;
						c_q     <= '0;
					end
				end
				S_RUN: begin
					if (adv) begin
						if (c_q == cmax) begin
							c_q <= '0;
							if (k_q == kmax) begin
								state_q <= S_IDLE;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/m3au_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Arithmetic datapath
// Operand select and multiply, add or compare, then shift, accumulate and
// saturate into the result register.
// ----------------------------------------------------------------------------
module m3au_dp #(
	parameter int FRACTION_BITS = m3au_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire m3au_pkg::uop_ctrl_t  ctrl,
	input  wire logic signed [31:0]   rd_a,
	input  wire logic signed [31:0]   rd_b,
	input  wire logic signed [31:0]   rd_v,
	input  wire logic signed [31:0]   scalar,
	input  wire logic                 rsp_stall,
	output logic                      rsp_valid,
	output m3au_pkg::rsp_t            rsp,
	output logic                      pipe_busy
);
	import m3au_pkg::*;

	uop_ctrl_t          ctrl_s1;
	uop_ctrl_t          ctrl_s2;
	logic signed [31:0] x_q;
	logic signed [31:0] p_q;
	logic signed [65:0] acc_q;
	logic               eq_q;
	logic signed [63:0] prod_s2;
	logic signed [32:0] sum_s2;
	logic               same_s2;
	logic signed [31:0] opl;
	logic signed [31:0] opr;
	logic signed [63:0] term;
	logic signed [63:0] addend;
	logic signed [65:0] acc_next;
	logic               eq_next;
	logic signed [31:0] value;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	assign pipe_busy = ctrl_s1.valid | ctrl_s2.valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		opl = rd_a;
		opr = rd_b;
		unique case (ctrl_s1.uop)
			UOP_SCALE: begin
				opl = scalar;
				opr = rd_a;
			end
			UOP_MV: begin
				opl = rd_v;
				opr = rd_a;
			end
			UOP_DF: begin
				opl = x_q;
				opr = rd_a;
			end
			UOP_DS: begin
				opl = p_q;
				opr = rd_a;
			end
			default: begin
				opl = rd_a;
				opr = rd_b;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= opl * opr;
			if (ctrl_s1.uop == UOP_SUB) begin
				sum_s2 <= {rd_a[31], rd_a} - {rd_b[31], rd_b};
			end else begin
				sum_s2 <= {rd_a[31], rd_a} + {rd_b[31], rd_b};
			end
			same_s2 <= (rd_a == rd_b);
			if (ctrl_s1.valid && ctrl_s1.uop == UOP_DX) begin
				x_q <= rd_a;
			end
		end
	end

	// Products are truncated toward minus infinity; a determinant term is
	// saturated before it joins the sum.
	always_comb begin
		term = prod_s2 >>> FRACTION_BITS;
		if (ctrl_s2.uop == UOP_DS) begin
			addend = 64'(sat32({{2{term[63]}}, term}));
			if (ctrl_s2.neg) begin
				addend = -addend;
			end
		end else begin
			addend = term;
		end
		acc_next = (ctrl_s2.first ? 66'sd0 : acc_q) + {{2{addend[63]}}, addend};
		eq_next  = (ctrl_s2.first | eq_q) & same_s2;
		unique case (ctrl_s2.uop)
			UOP_ADD, UOP_SUB: value = sat32({{33{sum_s2[32]}}, sum_s2});
			UOP_SCALE:        value = sat32({{2{term[63]}}, term});
			UOP_EQ:           value = 32'sd0;
			default:          value = sat32(acc_next);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_s2.valid) begin
			if (ctrl_s2.uop == UOP_MUL || ctrl_s2.uop == UOP_MV || ctrl_s2.uop == UOP_DS) begin
				acc_q <= acc_next;
			end
			if (ctrl_s2.uop == UOP_EQ) begin
				eq_q <= eq_next;
			end
			if (ctrl_s2.uop == UOP_DF) begin
				p_q <= sat32({{2{term[63]}}, term});
			end
			if (ctrl_s2.emit) begin
				rsp_q.result   <= value;
				rsp_q.position <= ctrl_s2.pos;
				rsp_q.last     <= ctrl_s2.last;
				rsp_q.equal    <= (ctrl_s2.uop == UOP_EQ) ? eq_next : 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && ctrl_s2.valid && ctrl_s2.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
